// File: rtl/ffdl_pkg.sv
`default_nettype none

package ffdl_pkg;

    localparam int LENGTH_BITS = 16;
    localparam int TIME_BITS   = 24;
    localparam int GAIN_BITS   = 16;
    localparam int GAIN_FRAC   = 15;
    localparam int CFG_BITS    = 24;

    localparam logic [LENGTH_BITS-1:0] LENGTH_RESET = 16'd32768;

    typedef enum logic [1:0] {
        CFG_DELAY_LENGTH  = 2'd0,
        CFG_DELAY_TIME    = 2'd1,
        CFG_FEEDBACK_GAIN = 2'd2,
        CFG_UNUSED        = 2'd3
    } t_cfg_index;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ_B,
        ST_INTERP,
        ST_MULT,
        ST_WRITE
    } t_state;

    typedef struct packed {
        logic in_ready;
        logic ram_re;
        logic sel_b;
        logic ram_we;
    } t_ctrl;

endpackage

`default_nettype wire

// File: rtl/ffdl_ram.sv
`default_nettype none

module ffdl_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 32768
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/ffdl_addr_gen.sv
`default_nettype none

module ffdl_addr_gen #(
    parameter int STORE_DEPTH   = 32768,
    parameter int FRACTION_BITS = 8
) (
    input  wire logic [ffdl_pkg::LENGTH_BITS-1:0] i_delay_length,
    input  wire logic [ffdl_pkg::TIME_BITS-1:0]   i_delay_time,
    input  wire logic [$clog2(STORE_DEPTH)-1:0]   i_wp,
    output logic      [$clog2(STORE_DEPTH)-1:0]   o_wp_eff,
    output logic                                  o_wp_last,
    output logic      [$clog2(STORE_DEPTH)-1:0]   o_addr_a,
    output logic      [$clog2(STORE_DEPTH)-1:0]   o_addr_b,
    output logic      [FRACTION_BITS-1:0]         o_frac
);

    localparam int AW = $clog2(STORE_DEPTH);
    localparam int LW = $clog2(STORE_DEPTH + 1);
    localparam int PW = ((LW + FRACTION_BITS > ffdl_pkg::TIME_BITS) ?
                         LW + FRACTION_BITS : ffdl_pkg::TIME_BITS) + 1;

    logic [31:0]   len_ext;
    logic [LW-1:0] len_eff;
    logic [PW-1:0] len_p;
    logic [PW-1:0] last_p;
    logic [PW-1:0] lenf;
    logic [PW-1:0] d_raw;
    logic [PW-1:0] d_eff;
    logic [PW-1:0] wpf;
    logic [PW-1:0] rp;
    logic [AW-1:0] rpi;

    always_comb begin
        len_ext = 32'(i_delay_length);
        if (len_ext == 32'd0) begin
            len_eff = LW'(1);
        end else if (len_ext > 32'(STORE_DEPTH)) begin
            len_eff = LW'(STORE_DEPTH);
        end else begin
            len_eff = LW'(len_ext);
        end
        len_p  = PW'(len_eff);
        last_p = len_p - PW'(1);

        // length shrunk to or below the write position: restart at entry 0
        o_wp_eff  = (PW'(i_wp) < len_p) ? i_wp : '0;
        o_wp_last = (PW'(o_wp_eff) == last_p);

        lenf  = len_p << FRACTION_BITS;
        d_raw = PW'(i_delay_time);
        d_eff = (d_raw > lenf) ? lenf : d_raw;
        wpf   = PW'(o_wp_eff) << FRACTION_BITS;
        if (wpf >= d_eff) begin
            rp = wpf - d_eff;
        end else begin
            rp = wpf + lenf - d_eff;
        end

        rpi      = AW'(rp >> FRACTION_BITS);
        o_frac   = rp[FRACTION_BITS-1:0];
        o_addr_a = rpi;
        o_addr_b = (PW'(rpi) == last_p) ? '0 : rpi + AW'(1);
    end

endmodule

`default_nettype wire

// File: rtl/fractional_feedback_delay_line.sv
`default_nettype none
// An accepted sample passes READ_B, INTERP, MULT and WRITE; o_out_valid is
// set by the write-back. One item at a time: two reads of the single-read-port
// store (interpolation neighbors), interpolate, feedback multiply, write back.
// A waiting result holds the write-back step until the output register frees.
// Reset: synchronous; config returns to defaults, write position to 0, fill mark
// to 0 so the store reads as zero until written. No clearing pass.
module fractional_feedback_delay_line #(
    parameter int STORE_DEPTH   = 32768,
    parameter int SAMPLE_BITS   = 24,
    parameter int FRACTION_BITS = 8
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [1:0]                          i_cfg_index,
    input  wire logic [ffdl_pkg::CFG_BITS-1:0]       i_cfg_data,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic signed [SAMPLE_BITS-1:0]       i_sample_in,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic signed [SAMPLE_BITS-1:0]            o_sample_out
);

    localparam int AW = $clog2(STORE_DEPTH);
    localparam int LW = $clog2(STORE_DEPTH + 1);
    localparam int SB = SAMPLE_BITS;
    localparam int F  = FRACTION_BITS;
    localparam int PB = SB + ffdl_pkg::GAIN_BITS;
    localparam logic signed [SB+1:0] SAT_HI = (SB+2)'((64'sd1 <<< (SB - 1)) - 64'sd1);
    localparam logic signed [SB+1:0] SAT_LO = -SAT_HI - (SB+2)'(1);

    // configuration
    logic        [ffdl_pkg::LENGTH_BITS-1:0] r_delay_length;
    logic        [ffdl_pkg::TIME_BITS-1:0]   r_delay_time;
    logic signed [ffdl_pkg::GAIN_BITS-1:0]   r_gain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay_length <= ffdl_pkg::LENGTH_RESET;
            r_delay_time   <= '0;
            r_gain         <= '0;
        end else if (i_cfg_we) begin
            case (ffdl_pkg::t_cfg_index'(i_cfg_index))
                ffdl_pkg::CFG_DELAY_LENGTH:
                    r_delay_length <= i_cfg_data[ffdl_pkg::LENGTH_BITS-1:0];
                ffdl_pkg::CFG_DELAY_TIME:
                    r_delay_time <= i_cfg_data[ffdl_pkg::TIME_BITS-1:0];
                ffdl_pkg::CFG_FEEDBACK_GAIN:
                    r_gain <= $signed(i_cfg_data[ffdl_pkg::GAIN_BITS-1:0]);
                default: begin
                end
            endcase
        end
    end

    // control
    ffdl_pkg::t_state r_state, n_state;
    ffdl_pkg::t_ctrl  ctrl;
    logic             in_acc;
    logic             out_free;

    logic [AW-1:0] r_wp, n_wp;
    logic [LW-1:0] r_fill;
    logic          r_out_valid;

    assign in_acc   = i_in_valid && ctrl.in_ready;
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ffdl_pkg::ST_IDLE:   if (i_in_valid) n_state = ffdl_pkg::ST_READ_B;
            ffdl_pkg::ST_READ_B: n_state = ffdl_pkg::ST_INTERP;
            ffdl_pkg::ST_INTERP: n_state = ffdl_pkg::ST_MULT;
            ffdl_pkg::ST_MULT:   n_state = ffdl_pkg::ST_WRITE;
            ffdl_pkg::ST_WRITE:  if (out_free) n_state = ffdl_pkg::ST_IDLE;
            default:             n_state = ffdl_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        ctrl = '0;
        case (r_state)
            ffdl_pkg::ST_IDLE: begin
                ctrl.in_ready = 1'b1;
                ctrl.ram_re   = 1'b1;
            end
            ffdl_pkg::ST_READ_B: begin
                ctrl.ram_re = 1'b1;
                ctrl.sel_b  = 1'b1;
            end
            ffdl_pkg::ST_WRITE: ctrl.ram_we = out_free;
            default: begin
            end
        endcase
    end

    assign o_in_ready = ctrl.in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ffdl_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // read addresses
    logic [AW-1:0] wp_eff;
    logic          wp_last;
    logic [AW-1:0] addr_a;
    logic [AW-1:0] addr_b;
    logic [F-1:0]  frac;

    ffdl_addr_gen #(
        .STORE_DEPTH   (STORE_DEPTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_addr_gen (
        .i_delay_length (r_delay_length),
        .i_delay_time   (r_delay_time),
        .i_wp           (r_wp),
        .o_wp_eff       (wp_eff),
        .o_wp_last      (wp_last),
        .o_addr_a       (addr_a),
        .o_addr_b       (addr_b),
        .o_frac         (frac)
    );

    logic [AW-1:0]          r_addr_b;
    logic [AW-1:0]          r_wpe;
    logic                   r_wp_last;
    logic [F-1:0]           r_frac;
    logic signed [SB-1:0]   r_x;
    logic                   r_a_ok, r_b_ok;

    // entries at or above the fill mark were never written and read as zero
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_addr_b  <= addr_b;
            r_wpe     <= wp_eff;
            r_wp_last <= wp_last;
            r_frac    <= frac;
            r_x       <= i_sample_in;
            r_a_ok    <= (LW'(addr_a) < r_fill);
        end
        if (ctrl.sel_b) begin
            r_b_ok <= (LW'(r_addr_b) < r_fill);
        end
    end

    // store
    logic [AW-1:0]        raddr;
    logic [SB-1:0]        rdata;
    logic signed [SB-1:0] wdata;

    assign raddr = ctrl.sel_b ? r_addr_b : addr_a;

    ffdl_ram #(
        .WIDTH (SB),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ctrl.ram_we),
        .i_waddr (r_wpe),
        .i_wdata (wdata),
        .i_re    (ctrl.ram_re && (ctrl.sel_b || i_in_valid)),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // interpolation
    logic signed [SB-1:0]     r_a;
    logic signed [SB-1:0]     b_val;
    logic signed [SB:0]       diff;
    logic signed [SB+F+1:0]   ip_prod;
    logic signed [SB+F+1:0]   ip_sum;
    logic signed [SB-1:0]     r_y;
    logic signed [PB-1:0]     r_prod;

    always_comb begin
        b_val   = r_b_ok ? $signed(rdata) : '0;
        diff    = (SB+1)'(b_val) - (SB+1)'(r_a);
        ip_prod = (SB+F+2)'($signed({1'b0, r_frac})) * (SB+F+2)'(diff);
        ip_sum  = ((SB+F+2)'(r_a) <<< F) + ip_prod;
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ffdl_pkg::ST_READ_B) begin
            r_a <= r_a_ok ? $signed(rdata) : '0;
        end
        if (r_state == ffdl_pkg::ST_INTERP) begin
            r_y <= SB'(ip_sum >>> F);
        end
        if (r_state == ffdl_pkg::ST_MULT) begin
            r_prod <= PB'(r_y) * PB'(r_gain);
        end
    end

    // feedback and saturation
    logic signed [SB:0]   fb;
    logic signed [SB+1:0] wsum;

    always_comb begin
        fb   = (SB+1)'(r_prod >>> ffdl_pkg::GAIN_FRAC);
        wsum = (SB+2)'(r_x) + (SB+2)'(fb);
        if (wsum > SAT_HI) begin
            wdata = SB'(SAT_HI);
        end else if (wsum < SAT_LO) begin
            wdata = SB'(SAT_LO);
        end else begin
            wdata = SB'(wsum);
        end
        n_wp = r_wp_last ? '0 : r_wpe + AW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp        <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (ctrl.ram_we) begin
                r_wp        <= n_wp;
                r_out_valid <= 1'b1;
                if (LW'(r_wpe) >= r_fill) begin
                    r_fill <= LW'(r_wpe) + LW'(1);
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.ram_we) begin
            o_sample_out <= r_y;
        end
    end

    assign o_out_valid = r_out_valid;

    a_accept_reads_b: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == ffdl_pkg::ST_READ_B))
        else $error("accepted item did not move on to second read");

    a_write_needs_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.ram_we |-> out_free)
        else $error("write-back while output register still full");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_ready && !ctrl.ram_we) |=> !r_out_valid)
        else $error("taken result shown again");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill <= LW'(STORE_DEPTH)) && (LW'(r_wp) < LW'(STORE_DEPTH)))
        else $error("fill mark or write position out of range");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ffdl_pkg::ST_IDLE) |-> !o_in_ready)
        else $error("input ready while an item is in flight");

endmodule

`default_nettype wire
